FILE: hw/rtl/iis_pkg.sv
// Shared widths, configuration codes and control types of the integral image stream.
package iis_pkg;

    localparam int PIX_W    = 8;
    localparam int ROWSUM_W = 18;
    localparam int SUM_W    = 28;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

    typedef struct packed {
        logic row_nz;
        logic row_end;
        logic frame_end;
    } t_pos_flags;

endpackage

FILE: hw/rtl/iis_pix_if.sv
// Pixel item channel.
interface iis_pix_if;
    logic                      valid;
    logic                      ready;
    logic [iis_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

FILE: hw/rtl/iis_res_if.sv
// Integral result item channel.
interface iis_res_if;
    logic                      valid;
    logic                      ready;
    logic [iis_pkg::SUM_W-1:0] integral_sum;
    logic                      row_end;
    logic                      frame_end;

    modport source (output valid, output integral_sum, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input integral_sum, input row_end, input frame_end,
                    output ready);
endinterface

FILE: hw/rtl/iis_ctrl.sv
// Frame position counters, row running sum and size configuration registers.
module iis_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int ROWW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [iis_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [iis_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_accept,
    input  logic [iis_pkg::PIX_W-1:0]     i_pixel,
    output logic [COLW-1:0]               o_col,
    output logic [iis_pkg::ROWSUM_W-1:0]  o_rowsum,
    output iis_pkg::t_pos_flags           o_flags
);

    localparam int CW = COLW + 1;
    localparam int RW = ROWW + 1;

    function automatic logic [CW-1:0] clamp_w(input logic [iis_pkg::CFG_W-1:0] v);
        logic [CW-1:0] res;
        if (v == '0) begin
            res = CW'(1);
        end else if ({21'd0, v} > 32'(MAX_WIDTH)) begin
            res = CW'(MAX_WIDTH);
        end else begin
            res = CW'(v);
        end
        return res;
    endfunction

    function automatic logic [RW-1:0] clamp_h(input logic [iis_pkg::CFG_W-1:0] v);
        logic [RW-1:0] res;
        if (v == '0) begin
            res = RW'(1);
        end else if ({21'd0, v} > 32'(MAX_HEIGHT)) begin
            res = RW'(MAX_HEIGHT);
        end else begin
            res = RW'(v);
        end
        return res;
    endfunction

    logic [CW-1:0]                  r_width;
    logic [RW-1:0]                  r_height;
    logic [COLW-1:0]                r_col, n_col;
    logic [ROWW-1:0]                r_row, n_row;
    logic [iis_pkg::ROWSUM_W-1:0]   r_rowsum, n_rowsum;
    logic [iis_pkg::ROWSUM_W-1:0]   rowsum_inc;
    logic                           row_end;
    logic                           frame_end;

    always_comb begin
        rowsum_inc = r_rowsum + iis_pkg::ROWSUM_W'(i_pixel);
        row_end    = ((CW'(r_col) + CW'(1)) >= r_width);
        frame_end  = row_end && ((RW'(r_row) + RW'(1)) >= r_height);
        n_col      = r_col;
        n_row      = r_row;
        n_rowsum   = r_rowsum;
        if (i_accept) begin
            if (row_end) begin
                n_col    = '0;
                n_rowsum = '0;
                n_row    = frame_end ? '0 : ROWW'(RW'(r_row) + RW'(1));
            end else begin
                n_col    = COLW'(CW'(r_col) + CW'(1));
                n_rowsum = rowsum_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= clamp_w(iis_pkg::CFG_SIZE_RESET);
            r_height <= clamp_h(iis_pkg::CFG_SIZE_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                iis_pkg::CFG_IMAGE_WIDTH:  r_width  <= clamp_w(i_cfg_data);
                iis_pkg::CFG_IMAGE_HEIGHT: r_height <= clamp_h(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_rowsum <= '0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_rowsum <= n_rowsum;
        end
    end

    assign o_col             = r_col;
    assign o_rowsum          = rowsum_inc;
    assign o_flags.row_nz    = (r_row != '0);
    assign o_flags.row_end   = row_end;
    assign o_flags.frame_end = frame_end;

    a_row_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && row_end |=> r_col == '0 && r_rowsum == '0)
        else $error("column or row sum not cleared at row end");

    a_frame_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && frame_end |=> r_row == '0)
        else $error("row count not cleared at frame end");

    a_frame_end_is_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_end |-> row_end)
        else $error("frame end without row end");

endmodule

FILE: hw/rtl/iis_line_mem.sv
// Line store of the previous row's integral values, registered read.
module iis_line_mem #(
    parameter int MAX_WIDTH = 1024,
    localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_re,
    input  logic [COLW-1:0]           i_raddr,
    output logic [iis_pkg::SUM_W-1:0] o_rdata,
    input  logic                      i_we,
    input  logic [COLW-1:0]           i_waddr,
    input  logic [iis_pkg::SUM_W-1:0] i_wdata
);

    logic [iis_pkg::SUM_W-1:0] r_mem [MAX_WIDTH];
    logic [iis_pkg::SUM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/iis_accum.sv
// Sum stage: adds the line store value, writes it back and holds the result item.
module iis_accum #(
    parameter int MAX_WIDTH = 1024,
    localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [COLW-1:0]              i_col,
    input  logic [iis_pkg::ROWSUM_W-1:0] i_rowsum,
    input  iis_pkg::t_pos_flags          i_flags,
    input  logic [iis_pkg::SUM_W-1:0]    i_rdata,
    output logic                         o_we,
    output logic [COLW-1:0]              o_waddr,
    output logic [iis_pkg::SUM_W-1:0]    o_wdata,
    iis_res_if.source                    o_res
);

    logic                         r_s1_valid;
    logic [COLW-1:0]              r_s1_col;
    logic [iis_pkg::ROWSUM_W-1:0] r_s1_rowsum;
    iis_pkg::t_pos_flags          r_s1_flags;
    logic                         r_byp_hit;
    logic [iis_pkg::SUM_W-1:0]    r_byp_sum;
    logic                         r_out_valid;
    logic [iis_pkg::SUM_W-1:0]    r_out_sum;
    logic                         r_out_row_end;
    logic                         r_out_frame_end;

    logic                         s1_adv;
    logic                         accept;
    logic [iis_pkg::SUM_W-1:0]    above;
    logic [iis_pkg::SUM_W-1:0]    s1_sum;

    always_comb begin
        s1_adv     = r_s1_valid && (!r_out_valid || o_res.ready);
        o_in_ready = !r_s1_valid || s1_adv;
        accept     = i_in_valid && o_in_ready;
        // previous item writes this column at the same edge as our read
        above      = r_byp_hit ? r_byp_sum : i_rdata;
        s1_sum     = iis_pkg::SUM_W'(r_s1_rowsum)
                   + (r_s1_flags.row_nz ? above : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp_hit  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_byp_hit  <= s1_adv && (r_s1_col == i_col);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
                r_byp_hit  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col    <= i_col;
            r_s1_rowsum <= i_rowsum;
            r_s1_flags  <= i_flags;
            r_byp_sum   <= s1_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= s1_adv || (r_out_valid && !o_res.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_sum       <= s1_sum;
            r_out_row_end   <= r_s1_flags.row_end;
            r_out_frame_end <= r_s1_flags.frame_end;
        end
    end

    assign o_we               = s1_adv;
    assign o_waddr            = r_s1_col;
    assign o_wdata            = s1_sum;
    assign o_res.valid        = r_out_valid;
    assign o_res.integral_sum = r_out_sum;
    assign o_res.row_end      = r_out_row_end;
    assign o_res.frame_end    = r_out_frame_end;

    a_byp_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp_hit |-> r_s1_valid)
        else $error("bypass flag set with empty sum stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_col) && $stable(r_s1_rowsum))
        else $error("stalled sum stage lost its item");

    a_out_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_frame_end |-> r_out_row_end)
        else $error("result frame end without row end");

endmodule

FILE: hw/rtl/integral_image_stream_top.sv
// Streaming summed-area table: one 28-bit integral value per 8-bit pixel item.
// A pixel accept registers the line store read and the sum stage item; the sum is then registered as the result.
// Throughput: 1 item per cycle while the result sink is ready; the line store has one read port and one write port.
// Reset (i_rst_n low, synchronous): position, row sum and item valids clear; sizes go to 1024.
// The line store is not cleared; row 0 of each frame does not use the value that it reads.
module integral_image_stream_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [iis_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [iis_pkg::CFG_W-1:0]     i_cfg_data,
    iis_pix_if.sink                       i_pix,
    iis_res_if.source                     o_res
);

    localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic                         accept;
    logic [COLW-1:0]              col;
    logic [iis_pkg::ROWSUM_W-1:0] rowsum;
    iis_pkg::t_pos_flags          flags;
    logic [iis_pkg::SUM_W-1:0]    rdata;
    logic                         we;
    logic [COLW-1:0]              waddr;
    logic [iis_pkg::SUM_W-1:0]    wdata;

    assign accept = i_pix.valid && i_pix.ready;

    iis_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_pixel    (i_pix.pixel),
        .o_col      (col),
        .o_rowsum   (rowsum),
        .o_flags    (flags)
    );

    iis_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (col),
        .o_rdata (rdata),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata)
    );

    iis_accum #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_col      (col),
        .i_rowsum   (rowsum),
        .i_flags    (flags),
        .i_rdata    (rdata),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_res      (o_res)
    );

endmodule

FILE: sim/integral_image_stream_top_tb.sv
// Self-checking testbench for the streaming integral image block: directed and random pixel streams.
module integral_image_stream_top_tb;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 1024;
    localparam int TOTAL_PIXELS = 1350;

    typedef struct packed {
        logic [iis_pkg::SUM_W-1:0] integral_sum;
        logic                      row_end;
        logic                      frame_end;
    } t_integral_item;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [iis_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [iis_pkg::CFG_W-1:0]     i_cfg_data;

    iis_pix_if pix_if();
    iis_res_if res_if();

    logic [iis_pkg::PIX_W-1:0]    pixel_q[$];
    t_integral_item               integral_q[$];
    logic [iis_pkg::SUM_W-1:0]    line_sums[MAX_W];
    logic [iis_pkg::ROWSUM_W-1:0] row_acc;
    int                           col_pos;
    int                           row_pos;
    int                           cols_filled;
    logic [iis_pkg::CFG_W-1:0]    cfg_width;
    logic [iis_pkg::CFG_W-1:0]    cfg_height;
    bit                           calm;
    int                           err_count;
    int                           pixels_sent;

    integral_image_stream_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int eff_size(input logic [iis_pkg::CFG_W-1:0] raw, input int max_size);
        if (raw == 0) return 1;
        if (raw > max_size) return max_size;
        return int'(raw);
    endfunction

    function automatic void integrate_pixel(input logic [iis_pkg::PIX_W-1:0] px);
        logic [iis_pkg::SUM_W-1:0] sum;
        t_integral_item            item;
        int                        w;
        int                        h;
        w = eff_size(cfg_width, MAX_W);
        h = eff_size(cfg_height, MAX_H);
        row_acc = row_acc + iis_pkg::ROWSUM_W'(px);
        sum = iis_pkg::SUM_W'(row_acc);
        if (row_pos > 0) sum = sum + line_sums[col_pos];
        line_sums[col_pos] = sum;
        if (col_pos + 1 > cols_filled) cols_filled = col_pos + 1;
        item.integral_sum = sum;
        item.row_end      = (col_pos + 1 >= w);
        item.frame_end    = item.row_end && (row_pos + 1 >= h);
        if (item.row_end) begin
            col_pos = 0;
            row_acc = '0;
            row_pos = item.frame_end ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        integral_q.push_back(item);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_result();
        t_integral_item want;
        if (integral_q.size() == 0) begin
            report_mismatch($sformatf("result with no pending item, sum %0d",
                                      res_if.integral_sum));
        end else begin
            want = integral_q.pop_front();
            if (res_if.integral_sum !== want.integral_sum)
                report_mismatch($sformatf("integral_sum %0d, want %0d",
                                          res_if.integral_sum, want.integral_sum));
            if (res_if.row_end !== want.row_end)
                report_mismatch($sformatf("row_end %b, want %b, sum %0d",
                                          res_if.row_end, want.row_end, want.integral_sum));
            if (res_if.frame_end !== want.frame_end)
                report_mismatch($sformatf("frame_end %b, want %b, sum %0d",
                                          res_if.frame_end, want.frame_end, want.integral_sum));
        end
    endtask

    // Pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready) integrate_pixel(pix_if.pixel);
            if (!pix_if.valid || pix_if.ready) begin
                if (pixel_q.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
                    pix_if.valid <= 1'b1;
                    pix_if.pixel <= pixel_q.pop_front();
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) check_result();
            res_if.ready <= calm || ($urandom_range(0, 99) >= 32);
        end
    end

    task automatic write_reg(input logic [iis_pkg::CFG_IDX_W-1:0] idx,
                             input logic [iis_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == iis_pkg::CFG_IMAGE_WIDTH) cfg_width = data;
        else cfg_height = data;
    endtask

    // A wider row below row 0 must not reach line store columns never written since reset.
    task automatic write_width(input logic [iis_pkg::CFG_W-1:0] raw);
        logic [iis_pkg::CFG_W-1:0] w;
        w = raw;
        if (row_pos > 0 && eff_size(w, MAX_W) > cols_filled) w = iis_pkg::CFG_W'(cols_filled);
        write_reg(iis_pkg::CFG_IMAGE_WIDTH, w);
    endtask

    task automatic push_pixel(input logic [iis_pkg::PIX_W-1:0] px);
        pixel_q.push_back(px);
        pixels_sent++;
    endtask

    task automatic drain();
        while (pixel_q.size() != 0 || pix_if.valid || integral_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [iis_pkg::CFG_W-1:0] rand_size(input int short_max);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return iis_pkg::CFG_W'($urandom_range(MAX_W + 1, 2047));
            2: return iis_pkg::CFG_W'($urandom_range(short_max + 1, 1024));
            default: return iis_pkg::CFG_W'($urandom_range(1, short_max));
        endcase
    endfunction

    function automatic logic [iis_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return iis_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int n;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = iis_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data   = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        res_if.ready = 1'b0;
        for (int k = 0; k < MAX_W; k++) line_sums[k] = '0;
        row_acc     = '0;
        col_pos     = 0;
        row_pos     = 0;
        cols_filled = 0;
        cfg_width   = iis_pkg::CFG_SIZE_RESET;
        cfg_height  = iis_pkg::CFG_SIZE_RESET;
        calm        = 1'b0;
        err_count   = 0;
        pixels_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes, start of row 0
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(8'd128);
        drain();
        // shrink width mid-row: next item closes the row
        write_width(11'd4);
        write_reg(iis_pkg::CFG_IMAGE_HEIGHT, 11'd2);
        push_pixel(8'd255);
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd1);
        push_pixel(8'd254);
        drain();
        // zero sizes act as one
        write_width(11'd0);
        write_reg(iis_pkg::CFG_IMAGE_HEIGHT, 11'd0);
        push_pixel(8'd170);
        push_pixel(8'd85);
        drain();
        // oversize acts as the maximum
        write_width(11'd2047);
        write_reg(iis_pkg::CFG_IMAGE_HEIGHT, 11'd2047);
        push_pixel(8'd255);
        push_pixel(8'd255);
        drain();
        write_width(11'd1);
        write_reg(iis_pkg::CFG_IMAGE_HEIGHT, 11'd3);
        push_pixel(8'd7);
        push_pixel(8'd255);
        push_pixel(8'd9);
        drain();
        // height shrink mid-frame ends the frame at the end of the current row
        write_width(11'd3);
        write_reg(iis_pkg::CFG_IMAGE_HEIGHT, 11'd5);
        push_pixel(8'd255);
        push_pixel(8'd255);
        push_pixel(8'd255);
        drain();
        write_reg(iis_pkg::CFG_IMAGE_HEIGHT, 11'd1);
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd255);
        drain();

        for (int phase = 0; pixels_sent < TOTAL_PIXELS; phase++) begin
            calm = (phase >= 6 && phase < 16) || ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 2) == 0) write_width(rand_size(16));
            if ($urandom_range(0, 2) == 0) write_reg(iis_pkg::CFG_IMAGE_HEIGHT, rand_size(8));
            n = $urandom_range(1, 40);
            repeat (n) push_pixel(rand_pixel());
            drain();
        end

        if (err_count == 0) begin
            $display("integral_image_stream_top test passed");
        end else begin
            $display("integral_image_stream_top test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("integral_image_stream_top test failed");
        $finish;
    end

endmodule
